>>> hw/rtl/multi_tap_keypad_entry_unit_assert.svh
// Assertion macros for the multi-tap keypad entry unit.
`ifndef MULTI_TAP_KEYPAD_ENTRY_UNIT_ASSERT_SVH
`define MULTI_TAP_KEYPAD_ENTRY_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define MTKE_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error("mtke assertion failed");
// Next-cycle implication, checked outside reset.
`define MTKE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error("mtke assertion failed");
`else
`define MTKE_ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define MTKE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

>>> hw/rtl/mtke_pkg.sv
// Package with the types, constants and keypad tables of the keypad entry unit.
package mtke_pkg;

    localparam int unsigned NUM_ROWS     = 4;
    localparam int unsigned NUM_COLS     = 3;
    localparam logic [15:0] TIMEOUT_RST  = 16'd800;
    localparam logic [3:0]  LAST_KEY     = 4'd11;

    // Keypad selection and multi-tap tracking state.
    typedef struct packed {
        logic [1:0]  row;
        logic [1:0]  col;
        logic        last_valid;
        logic [3:0]  last_key;
        logic [31:0] last_ms;
        logic [2:0]  cycle;
        logic        nonempty;
    } t_key_state;

    // One result item; the first field sits in the highest bits.
    typedef struct packed {
        logic       redraw;
        logic       clear_counter;
        logic       replace_last;
        logic [6:0] char_code;
        logic       char_valid;
        logic [1:0] col_selected;
        logic [1:0] row_selected;
    } t_result;

    // Number of characters on each key.
    function automatic logic [2:0] key_len(input logic [3:0] key);
        logic [2:0] len;
        case (key)
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd7: len = 3'd4;
            4'd6, 4'd8:                          len = 3'd5;
            default:                             len = 3'd1;
        endcase
        return len;
    endfunction

    // Character at a given position on a key.
    function automatic logic [6:0] key_char(input logic [3:0] key, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (key)
            4'd0: c = "1";
            4'd1: begin
                case (idx)
                    3'd0: c = "2";
                    3'd1: c = "a";
                    3'd2: c = "b";
                    default: c = "c";
                endcase
            end
            4'd2: begin
                case (idx)
                    3'd0: c = "3";
                    3'd1: c = "d";
                    3'd2: c = "e";
                    default: c = "f";
                endcase
            end
            4'd3: begin
                case (idx)
                    3'd0: c = "4";
                    3'd1: c = "g";
                    3'd2: c = "h";
                    default: c = "i";
                endcase
            end
            4'd4: begin
                case (idx)
                    3'd0: c = "5";
                    3'd1: c = "j";
                    3'd2: c = "k";
                    default: c = "l";
                endcase
            end
            4'd5: begin
                case (idx)
                    3'd0: c = "6";
                    3'd1: c = "m";
                    3'd2: c = "n";
                    default: c = "o";
                endcase
            end
            4'd6: begin
                case (idx)
                    3'd0: c = "7";
                    3'd1: c = "p";
                    3'd2: c = "q";
                    3'd3: c = "r";
                    default: c = "s";
                endcase
            end
            4'd7: begin
                case (idx)
                    3'd0: c = "8";
                    3'd1: c = "t";
                    3'd2: c = "u";
                    default: c = "v";
                endcase
            end
            4'd8: begin
                case (idx)
                    3'd0: c = "9";
                    3'd1: c = "w";
                    3'd2: c = "x";
                    3'd3: c = "y";
                    default: c = "z";
                endcase
            end
            4'd9:  c = "*";
            4'd10: c = "0";
            default: c = "#";
        endcase
        return c[6:0];
    endfunction

endpackage

>>> hw/rtl/mtke_step.sv
// Combinational step logic: applies one encoder poll to the keypad state.
module mtke_step (
    input  mtke_pkg::t_key_state i_state,
    input  logic [15:0]          i_tap_timeout,
    input  logic [15:0]          i_encoder_delta,
    input  logic                 i_button_level,
    input  logic [31:0]          i_now_ms,
    output mtke_pkg::t_key_state o_state,
    output mtke_pkg::t_result    o_result
);
    import mtke_pkg::*;

    logic        left;
    logic        right;
    logic        pressed;
    logic [1:0]  row_nx;
    logic [1:0]  col_nx;
    logic [3:0]  key_raw;
    logic [3:0]  key;
    logic [2:0]  len;
    logic [31:0] elapsed;
    logic        repeat_tap;
    logic [2:0]  idx_step;
    logic [2:0]  idx;

    // Decode the poll: signed thresholds on the count, active-low button.
    assign left    = $signed(i_encoder_delta) < -16'sd1;
    assign right   = $signed(i_encoder_delta) > 16'sd1;
    assign pressed = ~i_button_level;

    // Selection moves with wrap, before any tap in the same poll.
    always_comb begin
        col_nx = i_state.col;
        if (left) begin
            col_nx = ({30'd0, i_state.col} + 32'd1 >= NUM_COLS) ? 2'd0 : i_state.col + 2'd1;
        end
        row_nx = i_state.row;
        if (pressed) begin
            row_nx = ({30'd0, i_state.row} + 32'd1 >= NUM_ROWS) ? 2'd0 : i_state.row + 2'd1;
        end
    end

    // Key number is row*3+col, clamped to the last key.
    assign key_raw = {1'b0, row_nx, 1'b0} + {2'b00, row_nx} + {2'b00, col_nx};
    assign key     = (key_raw > LAST_KEY) ? LAST_KEY : key_raw;
    assign len     = key_len(key);

    // A repeat tap hits the same key inside the wrapping time window.
    assign elapsed    = i_now_ms - i_state.last_ms;
    assign repeat_tap = i_state.last_valid && (i_state.last_key == key)
                        && (elapsed < {16'd0, i_tap_timeout});

    // Cycle index steps on a repeat and wraps after the key's last character.
    always_comb begin
        if (repeat_tap) begin
            idx_step = ({1'b0, i_state.cycle} + 4'd1 >= {1'b0, len}) ? 3'd0
                                                                   : i_state.cycle + 3'd1;
        end else begin
            idx_step = 3'd0;
        end
        idx = (idx_step >= len) ? 3'd0 : idx_step;
    end

    // Next state and result.
    always_comb begin
        o_state     = i_state;
        o_state.row = row_nx;
        o_state.col = col_nx;
        if (right) begin
            o_state.last_valid = 1'b1;
            o_state.last_key   = key;
            o_state.last_ms    = i_now_ms;
            o_state.cycle      = idx;
            o_state.nonempty   = 1'b1;
        end

        o_result.row_selected  = row_nx;
        o_result.col_selected  = col_nx;
        o_result.char_valid    = right;
        o_result.char_code     = right ? key_char(key, idx) : 7'd0;
        o_result.replace_last  = right && repeat_tap && i_state.nonempty;
        o_result.clear_counter = left || right;
        o_result.redraw        = left || pressed || right;
    end

endmodule

>>> hw/rtl/multi_tap_keypad_entry_unit.sv
// Top level of the multi-tap keypad entry unit: handshake, registers and config port.
//
// The input stream carries one encoder poll per item. Each poll may step the
// selected keypad column (left turn), step the row (button press) and tap the
// selected key (right turn). Every accepted item gives exactly one result item
// on the output stream: selection, character, replace flag, clear request and
// redraw flag.
// An accepted item lands in an input register; when the result register is free
// or its item is being taken, the step logic updates the keypad state and loads
// the result register. One item is accepted per cycle while the receiver takes
// results; the state update in the step logic is combinational.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; after that s_axis_tready falls until the
// result is taken.
// Synchronous reset clears the selection to row 0 column 0, forgets the last
// tap, empties the message flag and sets tap_timeout to 800 ms.
// The APB port holds tap_timeout at byte address 0; write it only while idle.
module multi_tap_keypad_entry_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items: [15:0] encoder_delta, [16] button_level, [48:17] now_ms.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    // Result items: [1:0] row_selected, [3:2] col_selected, [4] char_valid,
    // [11:5] char_code, [12] replace_last, [13] clear_counter, [14] redraw.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mtke_pkg::*;

    logic        r_in_valid;
    logic [15:0] r_in_delta;
    logic        r_in_button;
    logic [31:0] r_in_now;
    logic        r_out_valid;
    t_result     r_out_data;
    t_key_state  r_state;
    logic [15:0] r_tap_timeout;

    t_key_state  n_state;
    t_result     n_result;
    logic        advance;
    logic        in_fire;

    // Handshake: the input register moves on when the result register is free or its item is taken.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_data};

    // Configuration register access.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_tap_timeout};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_timeout <= TIMEOUT_RST;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_tap_timeout <= pwdata[15:0];
        end
    end

    // Step logic between the input register and the result register.
    mtke_step u_step (
        .i_state         (r_state),
        .i_tap_timeout   (r_tap_timeout),
        .i_encoder_delta (r_in_delta),
        .i_button_level  (r_in_button),
        .i_now_ms        (r_in_now),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_delta  <= s_axis_tdata[15:0];
            r_in_button <= s_axis_tdata[16];
            r_in_now    <= s_axis_tdata[48:17];
        end
        if (advance) begin
            r_out_data <= n_result;
        end
    end

`include "multi_tap_keypad_entry_unit_assert.svh"

    `MTKE_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, r_in_valid && r_out_valid && !m_axis_tready)
    `MTKE_ASSERT_IMPL(a_col_range, i_clk, i_rst_n, r_out_valid, r_out_data.col_selected != 2'd3)
    `MTKE_ASSERT_IMPL(a_replace_tap, i_clk, i_rst_n, r_out_valid && r_out_data.replace_last, r_out_data.char_valid)
    `MTKE_ASSERT_NEXT(a_tap_state, i_clk, i_rst_n, advance && n_result.char_valid, r_state.last_valid && r_state.nonempty && r_out_data.clear_counter)

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the multi-tap keypad entry unit with a built-in predictor.
`timescale 1ns / 1ps

module tb_top;
    import mtke_pkg::*;

    localparam logic [2:0] ADDR_TAP_TIMEOUT = 3'd0;
    localparam logic [2:0] ADDR_SPARE       = 3'd4;
    localparam int         STALL_LIMIT      = 1000;
    localparam int         HOLD_CYCLES      = 120;
    localparam int         SETTLE_CYCLES    = 4;

    // One encoder poll as it is packed onto the input stream.
    typedef struct {
        logic [15:0] delta;
        logic        btn;
        logic [31:0] stamp;
    } t_enc_poll;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // Fields: [15:0] encoder_delta, [16] button_level, [48:17] now_ms.
    logic [55:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // Fields: [1:0] row_selected, [3:2] col_selected, [4] char_valid,
    // [11:5] char_code, [12] replace_last, [13] clear_counter, [14] redraw.
    logic [15:0] m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: selection, last tap and the tap window.
    int unsigned sel_row        = 0;
    int unsigned sel_col        = 0;
    logic        key_used       = 1'b0;
    int unsigned prev_key       = 0;
    logic [31:0] prev_tap_stamp = '0;
    int unsigned glyph_pos      = 0;
    logic        msg_has_text   = 1'b0;
    logic [15:0] win_ms         = TIMEOUT_RST;

    t_enc_poll   pending_polls[$];
    t_result     expected_entries[$];
    t_enc_poll   next_poll;
    t_result     got_entry;
    t_result     want_entry;

    logic        poll_taken   = 1'b0;
    logic        steady_run   = 1'b0;
    logic        moved;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          hold_left    = 0;
    int          dead_cycles  = 0;
    int          err_count    = 0;
    int          polls_queued = 0;
    int          polls_seen   = 0;
    int          entries_checked = 0;
    int          taps_seen    = 0;
    int          repeats_seen = 0;
    int          replaces_seen = 0;
    int          settings_used = 1;
    logic [31:0] clock_ms     = '0;

    multi_tap_keypad_entry_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Characters printed on each key, in tap order.
    function automatic string key_glyphs(input int unsigned key);
        string s;
        case (key)
            0:       s = "1";
            1:       s = "2abc";
            2:       s = "3def";
            3:       s = "4ghi";
            4:       s = "5jkl";
            5:       s = "6mno";
            6:       s = "7pqrs";
            7:       s = "8tuv";
            8:       s = "9wxyz";
            9:       s = "*";
            10:      s = "0";
            default: s = "#";
        endcase
        return s;
    endfunction

    // Applies one poll to the predictor state and returns the entry it should produce.
    function automatic t_result predict_entry(input logic [15:0] delta_raw,
                                              input logic btn_level,
                                              input logic [31:0] stamp);
        t_result     res;
        int          delta;
        logic        turn_left;
        logic        turn_right;
        logic        pressed;
        logic        again;
        int unsigned key;
        int unsigned span;
        string       glyphs;
        byte         ch;
        logic [31:0] elapsed;
        delta      = $signed(delta_raw);
        turn_left  = (delta < -1);
        turn_right = (delta > 1);
        pressed    = !btn_level;
        res        = '0;
        // Selection moves first, so a tap uses the key selected after the move.
        if (turn_left) begin
            sel_col = (sel_col + 1 >= NUM_COLS) ? 0 : sel_col + 1;
        end
        if (pressed) begin
            sel_row = (sel_row + 1 >= NUM_ROWS) ? 0 : sel_row + 1;
        end
        if (turn_right) begin
            key     = sel_row * NUM_COLS + sel_col;
            glyphs  = key_glyphs(key);
            span    = glyphs.len();
            elapsed = stamp - prev_tap_stamp;
            again   = key_used && (prev_key == key) && (elapsed < {16'd0, win_ms});
            if (again) begin
                glyph_pos = (glyph_pos + 1 >= span) ? 0 : glyph_pos + 1;
            end else begin
                glyph_pos = 0;
            end
            ch               = glyphs[glyph_pos];
            res.char_valid   = 1'b1;
            res.char_code    = ch[6:0];
            res.replace_last = again && msg_has_text;
            key_used         = 1'b1;
            prev_key         = key;
            prev_tap_stamp   = stamp;
            msg_has_text     = 1'b1;
            taps_seen++;
            if (again) repeats_seen++;
            if (res.replace_last) replaces_seen++;
        end
        res.row_selected  = sel_row[1:0];
        res.col_selected  = sel_col[1:0];
        res.clear_counter = turn_left || turn_right;
        res.redraw        = turn_left || pressed || turn_right;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic add_poll(input logic [15:0] delta, input logic btn,
                            input logic [31:0] stamp);
        t_enc_poll p;
        p.delta = delta;
        p.btn   = btn;
        p.stamp = stamp;
        pending_polls.push_back(p);
        polls_queued++;
    endtask

    function automatic logic [15:0] left_delta();
        return 16'($urandom_range(32768, 65534));
    endfunction

    function automatic logic [15:0] right_delta();
        return 16'($urandom_range(2, 32767));
    endfunction

    // Time between taps: mostly inside the window, some right on its edge, some far out.
    function automatic logic [31:0] tap_gap();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3, 4: return (win_ms == 0) ? $urandom_range(0, 3)
                                                : $urandom_range(0, win_ms - 1);
            5:             return win_ms;
            6:             return (win_ms == 0) ? 0 : win_ms - 1;
            7, 8:          return win_ms + $urandom_range(1, 3000);
            default:       return $urandom;
        endcase
    endfunction

    // Short directed run at the reset timeout of 800 ms.
    task automatic queue_directed();
        // Polls that do nothing: zero count and the counts just inside the dead band.
        add_poll(16'h0000, 1'b1, 32'd0);
        add_poll(16'h0001, 1'b1, 32'd5);
        add_poll(16'hFFFF, 1'b1, 32'd6);
        // First tap ever appends; a repeat on a one-character key stays put and replaces.
        add_poll(16'h0002, 1'b1, 32'd10);
        add_poll(16'h7FFF, 1'b1, 32'd20);
        // Move to key "2abc" and cycle through it until it wraps.
        add_poll(16'hFFFE, 1'b1, 32'd30);
        add_poll(16'd100,  1'b1, 32'd40);
        add_poll(16'd50,   1'b1, 32'd100);
        add_poll(16'd50,   1'b1, 32'd200);
        add_poll(16'd50,   1'b1, 32'd300);
        add_poll(16'd50,   1'b1, 32'd400);
        // Exactly the timeout is too late; one less is still a repeat.
        add_poll(16'd50,   1'b1, 32'd1200);
        add_poll(16'd50,   1'b1, 32'd1999);
        // Left turn and press together, then a press with a tap on the five-character key.
        add_poll(16'h8000, 1'b0, 32'd2000);
        add_poll(16'd5,    1'b0, 32'd2001);
        add_poll(16'd5,    1'b1, 32'd2002);
        add_poll(16'd5,    1'b1, 32'd2003);
        add_poll(16'd5,    1'b1, 32'd2004);
        add_poll(16'd5,    1'b1, 32'd2005);
        add_poll(16'd5,    1'b1, 32'd2006);
        // Press to the last row, then taps across the timestamp wrap.
        add_poll(16'h0000, 1'b0, 32'd2007);
        add_poll(16'd3,    1'b1, 32'hFFFF_FFF0);
        add_poll(16'd3,    1'b1, 32'd5);
        // Column and row both wrap back to zero.
        add_poll(16'hFFFE, 1'b1, 32'd6);
        add_poll(16'h4000, 1'b0, 32'd7);
        clock_ms = 32'd7;
    endtask

    // Random part: mostly steer-then-tap sessions, the rest raw noise.
    task automatic queue_random(input int count);
        int stop;
        int n;
        stop = polls_queued + count;
        while (polls_queued < stop) begin
            if ($urandom_range(0, 9) < 7) begin
                n = $urandom_range(0, 2);
                repeat (n) begin
                    clock_ms += $urandom_range(0, 300);
                    add_poll(left_delta(), 1'b1, clock_ms);
                end
                n = $urandom_range(0, 3);
                repeat (n) begin
                    clock_ms += $urandom_range(0, 300);
                    add_poll(16'($urandom_range(0, 2) - 1), 1'b0, clock_ms);
                end
                n = $urandom_range(1, 7);
                repeat (n) begin
                    clock_ms += tap_gap();
                    add_poll(right_delta(), ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1,
                             clock_ms);
                end
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        clock_ms = $urandom;
                    end else begin
                        clock_ms += $urandom_range(0, 2000);
                    end
                    add_poll(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                             clock_ms);
                end
            end
            // Now and then park the clock just short of its wrap.
            if ($urandom_range(0, 39) == 0) begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            end
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TAP_TIMEOUT) begin
            win_ms = data[15:0];
            settings_used++;
        end
    endtask

    task automatic check_timeout_reg();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TAP_TIMEOUT;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {16'd0, win_ms}) begin
            $display("%0t: tap_timeout readback mismatch, expected %0h, actual %0h",
                     $time, {16'd0, win_ms}, prdata);
            err_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every poll is taken and every entry has come back, then settle.
    // The check runs at the rising edge, after the sender's outputs have settled.
    task automatic drain();
        while (pending_polls.size() != 0 || s_axis_tvalid || expected_entries.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Sender: presents the next pending poll once the current one is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (poll_taken || !s_axis_tvalid) begin
                poll_taken = 1'b0;
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_polls.size() != 0) begin
                    next_poll = pending_polls.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, next_poll.stamp, next_poll.btn, next_poll.delta};
                    if (!steady_run && hold_left == 0 && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(1, 15);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the unit up.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!steady_run && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted poll and checks each accepted entry.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_entries.push_back(predict_entry(s_axis_tdata[15:0], s_axis_tdata[16],
                                                         s_axis_tdata[48:17]));
                poll_taken = 1'b1;
                polls_seen++;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved     = 1'b1;
                got_entry = m_axis_tdata[14:0];
                if (expected_entries.size() == 0) begin
                    $display("%0t: entry with none expected, expected nothing, actual %0h",
                             $time, m_axis_tdata);
                    err_count++;
                end else begin
                    want_entry = expected_entries.pop_front();
                    check_field("row_selected", want_entry.row_selected,
                                got_entry.row_selected);
                    check_field("col_selected", want_entry.col_selected,
                                got_entry.col_selected);
                    check_field("char_valid", want_entry.char_valid, got_entry.char_valid);
                    check_field("char_code", want_entry.char_code, got_entry.char_code);
                    check_field("replace_last", want_entry.replace_last,
                                got_entry.replace_last);
                    check_field("clear_counter", want_entry.clear_counter,
                                got_entry.clear_counter);
                    check_field("redraw", want_entry.redraw, got_entry.redraw);
                    entries_checked++;
                end
            end
            dead_cycles = moved ? 0 : dead_cycles + 1;
            if (dead_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, dead_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Run sequence: reset, then one block of polls per timeout setting.
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timeout of 800 ms.
        check_timeout_reg();
        queue_directed();
        queue_random(250);
        drain();

        // Zero window: no tap ever repeats.
        apb_write(ADDR_TAP_TIMEOUT, 32'd0);
        check_timeout_reg();
        queue_random(250);
        drain();

        // Widest window, with the receiver holding off long enough to fill the unit.
        apb_write(ADDR_TAP_TIMEOUT, 32'd65535);
        check_timeout_reg();
        hold_left = HOLD_CYCLES;
        queue_random(300);
        drain();

        // A write to an unmapped address must leave the timeout alone.
        apb_write(ADDR_SPARE, $urandom);
        check_timeout_reg();
        apb_write(ADDR_TAP_TIMEOUT, 32'd1);
        check_timeout_reg();
        queue_random(250);
        drain();

        apb_write(ADDR_TAP_TIMEOUT, $urandom_range(2, 5000));
        check_timeout_reg();
        queue_random(300);
        drain();

        // Back to the reset value, streaming with no idling on either side.
        apb_write(ADDR_TAP_TIMEOUT, {16'd0, TIMEOUT_RST});
        check_timeout_reg();
        steady_run = 1'b1;
        gap_left   = 0;
        stall_left = 0;
        queue_random(400);
        drain();

        $display("Run covered %0d polls and %0d checked entries over %0d timeout settings.",
                 polls_seen, entries_checked, settings_used);
        $display("Taps: %0d, repeat taps: %0d, replacements: %0d.",
                 taps_seen, repeats_seen, replaces_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
